// ===== design/mnsq_pkg.sv =====
// shared types, constants and scale tables for the note scale quantizer
// no dependencies; used by mnsq_regs and midi_note_scale_quantizer_unit
package mnsq_pkg;

  localparam int NoteW          = 7;
  localparam int SemisPerOctave = 12;
  localparam int NoteMax        = 127;
  localparam int SearchSpan     = 6;
  localparam int AddrW          = 5;
  localparam int DataW          = 32;

  localparam logic [11:0] ChromaticMask = 12'hFFF;

  localparam logic signed [5:0] TransposeMin = -6'sd24;
  localparam logic signed [5:0] TransposeMax = 6'sd24;
  localparam logic signed [2:0] OctaveMin    = -3'sd3;

  typedef enum logic [2:0] {
    REG_KEY       = 3'd0,
    REG_MODE      = 3'd1,
    REG_LOCK      = 3'd2,
    REG_TRANSPOSE = 3'd3,
    REG_OCTAVE    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_CHROMATIC  = 3'd0,
    MODE_MAJOR      = 3'd1,
    MODE_MINOR      = 3'd2,
    MODE_MAJOR_PENT = 3'd3,
    MODE_MINOR_PENT = 3'd4,
    MODE_BLUES      = 3'd5
  } scale_mode_t;

  typedef struct packed {
    logic [3:0]        key;
    logic [2:0]        mode;
    logic              lock;
    logic signed [5:0] transpose;
    logic signed [2:0] octave;
  } cfg_t;

  // bit n set means n semitones above the root are in the scale
  function automatic logic [11:0] scale_mask(input logic [2:0] mode);
    logic [11:0] m;
    case (scale_mode_t'(mode))
      MODE_MAJOR:      m = 12'hAB5;
      MODE_MINOR:      m = 12'h5AD;
      MODE_MAJOR_PENT: m = 12'h295;
      MODE_MINOR_PENT: m = 12'h4A9;
      MODE_BLUES:      m = 12'h4E9;
      default:         m = ChromaticMask;
    endcase
    return m;
  endfunction

endpackage

// ===== design/mnsq_regs.sv =====
// apb register file for the quantizer settings, with write-side clamping
// depends on mnsq_pkg
module mnsq_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [mnsq_pkg::AddrW-1:0] paddr,
  input  logic [mnsq_pkg::DataW-1:0] pwdata,
  output logic [mnsq_pkg::DataW-1:0] prdata,
  output logic                   pready,
  output mnsq_pkg::cfg_t         cfg
);
  import mnsq_pkg::*;

  logic              wr;
  reg_idx_t          idx;
  logic signed [5:0] tr_w;
  logic signed [5:0] tr_clamped;
  logic signed [2:0] oct_w;
  logic signed [2:0] oct_clamped;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign tr_w   = signed'(pwdata[5:0]);
  assign oct_w  = signed'(pwdata[2:0]);

  always_comb begin
    if (tr_w < TransposeMin) begin
      tr_clamped = TransposeMin;
    end else if (tr_w > TransposeMax) begin
      tr_clamped = TransposeMax;
    end else begin
      tr_clamped = tr_w;
    end
    oct_clamped = (oct_w < OctaveMin) ? OctaveMin : oct_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_KEY:       cfg.key       <= pwdata[3:0];
        REG_MODE:      cfg.mode      <= pwdata[2:0];
        REG_LOCK:      cfg.lock      <= pwdata[0];
        REG_TRANSPOSE: cfg.transpose <= tr_clamped;
        REG_OCTAVE:    cfg.octave    <= oct_clamped;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY:       prdata = {28'd0, cfg.key};
      REG_MODE:      prdata = {29'd0, cfg.mode};
      REG_LOCK:      prdata = {31'd0, cfg.lock};
      REG_TRANSPOSE: prdata = {{26{cfg.transpose[5]}}, cfg.transpose};
      REG_OCTAVE:    prdata = {{29{cfg.octave[2]}}, cfg.octave};
      default:       prdata = '0;
    endcase
  end

  a_tr_range: assert property (@(posedge clk) disable iff (rst)
      cfg.transpose >= TransposeMin && cfg.transpose <= TransposeMax)
    else $error("transpose register out of range");

  a_oct_range: assert property (@(posedge clk) disable iff (rst)
      cfg.octave >= OctaveMin)
    else $error("octave register below minimum");

endmodule

// ===== design/midi_note_scale_quantizer_unit.sv =====
// note scale quantizer: four-stage pipeline, snaps notes to a scale then transposes
// depends on mnsq_pkg and mnsq_regs
// throughput: one item per cycle while the output is not stalled; each stage holds
//   one item and loads when it is empty or when the stage after it moves, so a
//   stall on the output backs up stage by stage
// reset: clears all stage valid bits and sets every setting register to zero
module midi_note_scale_quantizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [6:0] note_in, [7] invalid flag
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] note_out, [7] zero
  output logic       m_axis_tuser,   // [0] note_valid
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [mnsq_pkg::AddrW-1:0] paddr,
  input  logic [mnsq_pkg::DataW-1:0] pwdata,
  output logic [mnsq_pkg::DataW-1:0] prdata,
  output logic       pready
);
  import mnsq_pkg::*;

  cfg_t cfg;

  mnsq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage load enables
  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;

  assign en4 = !v4 || m_axis_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  // stage 1: note mod 12 via reciprocal multiply
  logic [NoteW-1:0] in_note;
  logic [12:0]      prod;
  logic [3:0]       quo;
  logic [NoteW-1:0] rem7;

  logic [NoteW-1:0] p1_note;
  logic             p1_inv;
  logic [3:0]       p1_nm12;

  assign in_note = s_axis_tdata[NoteW-1:0];
  assign prod    = {6'd0, in_note} * 13'd43;
  assign quo     = prod[12:9];
  assign rem7    = in_note - {quo, 3'b000} - {1'b0, quo, 2'b00};

  // stage 2: pitch class relative to key, scale mask rotated to the note
  logic [3:0]  kmod;
  logic [3:0]  rel;
  logic [11:0] mask;
  logic [23:0] dbl;

  logic [NoteW-1:0] p2_note;
  logic             p2_inv;
  logic [11:0]      p2_rot;
  logic             p2_snap;

  assign kmod = (cfg.key >= 4'd12) ? cfg.key - 4'd12 : cfg.key;
  assign rel  = (p1_nm12 >= kmod) ? p1_nm12 - kmod : p1_nm12 + 4'd12 - kmod;
  assign mask = scale_mask(cfg.mode);
  assign dbl  = {mask, mask};

  // stage 3: nearest scale note, lower candidate first
  logic [NoteW-1:0] snapped;
  logic             found;

  logic [NoteW-1:0] p3_note;
  logic             p3_inv;

  always_comb begin
    snapped = p2_note;
    found   = p2_rot[0];
    for (int d = 1; d <= SearchSpan; d++) begin
      if (!found) begin
        if ({1'b0, p2_note} >= 8'(d) && p2_rot[SemisPerOctave-d]) begin
          snapped = p2_note - 7'(d);
          found   = 1'b1;
        end else if ({1'b0, p2_note} + 8'(d) <= 8'(NoteMax) && p2_rot[d]) begin
          snapped = p2_note + 7'(d);
          found   = 1'b1;
        end
      end
    end
    if (!p2_snap) begin
      snapped = p2_note;
    end
  end

  // stage 4: transpose, octave shift and saturation
  logic signed [9:0] oct_ext;
  logic signed [9:0] sum;
  logic [NoteW-1:0]  sat;

  logic [NoteW-1:0] out_note;
  logic             out_ok;

  assign oct_ext = {{7{cfg.octave[2]}}, cfg.octave};
  assign sum = signed'({3'b000, p3_note}) + {{4{cfg.transpose[5]}}, cfg.transpose}
             + (oct_ext <<< 3) + (oct_ext <<< 2);

  always_comb begin
    if (sum < 10'sd0) begin
      sat = '0;
    end else if (sum > 10'(NoteMax)) begin
      sat = 7'(NoteMax);
    end else begin
      sat = sum[NoteW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_note <= in_note;
      p1_inv  <= s_axis_tdata[7];
      p1_nm12 <= rem7[3:0];
    end
    if (en2) begin
      p2_note <= p1_note;
      p2_inv  <= p1_inv;
      p2_rot  <= dbl[rel +: 12];
      p2_snap <= cfg.lock && (mask != ChromaticMask);
    end
    if (en3) begin
      p3_note <= snapped;
      p3_inv  <= p2_inv;
    end
    if (en4) begin
      out_note <= p3_inv ? '0 : sat;
      out_ok   <= !p3_inv;
    end
  end

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {1'b0, out_note};
  assign m_axis_tuser  = out_ok;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("invalid note result not zero");

  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
      !s_axis_tready |-> v1 && v2 && v3 && v4)
    else $error("input stalled with a free stage");

  a_empty_latency: assert property (@(posedge clk) disable iff (rst)
      s_axis_tvalid && s_axis_tready && !v1 && !v2 && !v3 && !v4
      |-> ##4 m_axis_tvalid)
    else $error("item did not reach the output in four cycles");

endmodule
